// File: rtl/pcm_pkg.sv
`timescale 1ns / 1ps
// pcm_pkg: types and constants shared by the priority ceiling mutex core
// and its channel interfaces. no dependencies.

package pcm_pkg;

    localparam int unsigned TASK_W = 16;
    localparam int unsigned PRIO_W = 8;

    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_QUEUED   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RELEASED = 2'd3;

    localparam logic [PRIO_W-1:0] RESET_CEILING = 8'd100;

    typedef logic [TASK_W-1:0] t_task;
    typedef logic [PRIO_W-1:0] t_prio;

    // one waiter as stored in the queue memory
    typedef struct packed {
        t_task task_id;
        t_prio prio;
    } t_entry;

    typedef struct packed {
        logic [1:0] status;
        logic       boost_valid;
        t_prio      boost_priority;
        logic       restore_valid;
        t_prio      restore_priority;
        logic       wake_valid;
        t_task      wake_task;
    } t_result;

endpackage

// File: rtl/pcm_in_if.sv
`timescale 1ns / 1ps
// pcm_in_if: request channel of the priority ceiling mutex (lock / unlock)
// depends on pcm_pkg

interface pcm_in_if import pcm_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  operation;
    t_task task_id;
    t_prio task_priority;

    modport source (output valid, output operation, output task_id,
                    output task_priority, input ready);
    modport sink   (input valid, input operation, input task_id,
                    input task_priority, output ready);
endinterface

// File: rtl/pcm_out_if.sv
`timescale 1ns / 1ps
// pcm_out_if: result channel of the priority ceiling mutex
// depends on pcm_pkg

interface pcm_out_if import pcm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       boost_valid;
    t_prio      boost_priority;
    logic       restore_valid;
    t_prio      restore_priority;
    logic       wake_valid;
    t_task      wake_task;

    modport source (output valid, output status, output boost_valid,
                    output boost_priority, output restore_valid,
                    output restore_priority, output wake_valid,
                    output wake_task, input ready);
    modport sink   (input valid, input status, input boost_valid,
                    input boost_priority, input restore_valid,
                    input restore_priority, input wake_valid,
                    input wake_task, output ready);
endinterface

// File: rtl/pcm_cfg_if.sv
`timescale 1ns / 1ps
// pcm_cfg_if: configuration write channel carrying the initial ceiling
// depends on pcm_pkg

interface pcm_cfg_if import pcm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_prio data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/priority_ceiling_mutex_core.sv
`timescale 1ns / 1ps
// priority_ceiling_mutex_core: one mutex with a priority ceiling and a
// priority-ordered wait queue held in a synchronous memory.
// depends on pcm_pkg, pcm_in_if, pcm_out_if, pcm_cfg_if
//
// usage:
//   i_in carries lock (operation 0) and unlock (operation 1) transactions,
//   o_out returns exactly one result transaction per request, and i_cfg
//   writes the initial ceiling, which also reloads the ceiling at once.
//   a request is taken only when the sequencer is idle. a grant, a drop
//   or an unlock with an empty queue goes straight to the finish state.
//   a queued lock walks the queue memory from its tail, one entry per
//   cycle, moving less urgent waiters up.
//   an unlock with waiters reads the head and shifts the rest down one
//   entry per cycle. the queue memory has a single write port and a
//   registered read port.
//   the result sits in an output register; while it waits the next
//   request can be accepted and processed, and the sequencer only holds
//   its following result until o_out.ready frees the register.
//   reset (synchronous, active low) empties the queue by its count, frees
//   the mutex and sets the ceiling to 100; no clearing pass is needed.

module priority_ceiling_mutex_core import pcm_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcm_in_if.sink     i_in,
    pcm_cfg_if.sink    i_cfg,
    pcm_out_if.source  o_out
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // queue memory, sorted by priority, fifo among equals
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;

    logic [2:0]    r_state,      n_state;
    logic          r_locked,     n_locked;
    t_prio         r_orig,       n_orig;
    logic          r_orig_valid, n_orig_valid;
    t_prio         r_ceiling,    n_ceiling;
    logic [CW-1:0] r_count,      n_count;
    logic [CW-1:0] r_pos,        n_pos;
    logic [AW-1:0] r_idx,        n_idx;
    t_entry        r_new,        n_new;
    t_result       r_res,        n_res;
    logic          r_out_valid,  n_out_valid;
    t_result       r_out,        n_out;

    logic [CW-1:0] count_m1;
    logic [CW-1:0] pos_m1;
    logic [CW-1:0] pos_m2;
    logic          accept;
    t_prio         lock_ceiling;

    assign count_m1 = r_count - CW'(1);
    assign pos_m1   = r_pos - CW'(1);
    assign pos_m2   = r_pos - CW'(2);
    assign accept   = i_in.valid && i_in.ready;
    assign lock_ceiling = (i_in.task_priority < r_ceiling) ? i_in.task_priority : r_ceiling;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_locked     = r_locked;
        n_orig       = r_orig;
        n_orig_valid = r_orig_valid;
        n_ceiling    = r_ceiling;
        n_count      = r_count;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_new        = r_new;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = r_new;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    n_new = '{task_id: i_in.task_id, prio: i_in.task_priority};
                    n_state = S_FIN;
                    if (i_in.operation == OP_LOCK) begin
                        n_ceiling = lock_ceiling;
                        if (!r_locked) begin
                            n_locked     = 1'b1;
                            n_orig       = i_in.task_priority;
                            n_orig_valid = 1'b1;
                            n_res.status = ST_GRANTED;
                            if (lock_ceiling < i_in.task_priority) begin
                                n_res.boost_valid    = 1'b1;
                                n_res.boost_priority = lock_ceiling;
                            end
                        end else if (r_count < DEPTH_C) begin
                            n_res.status = ST_QUEUED;
                            if (r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = n_new;
                                n_count = CW'(1);
                            end else begin
                                // start at the tail and walk toward the head
                                rd_en   = 1'b1;
                                rd_addr = count_m1[AW-1:0];
                                n_pos   = r_count;
                                n_state = S_INS;
                            end
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end else begin
                        n_res.status = ST_RELEASED;
                        if (r_orig_valid && (i_in.task_priority != r_orig)) begin
                            n_res.restore_valid    = 1'b1;
                            n_res.restore_priority = r_orig;
                        end
                        n_orig_valid = 1'b0;
                        n_orig       = '0;
                        n_locked     = 1'b0;
                        if (r_count != '0) begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_idx   = '0;
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_INS: begin
                // r_rd_data holds the entry just below the hole at r_pos
                if (r_rd_data.prio > r_new.prio) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[AW-1:0];
                    wr_data = r_rd_data;
                    n_pos   = pos_m1;
                    if (r_pos == CW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_m2[AW-1:0];
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[AW-1:0];
                    wr_data = r_new;
                    n_count = r_count + CW'(1);
                    n_state = S_FIN;
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[AW-1:0];
                wr_data = r_new;
                n_count = r_count + CW'(1);
                n_state = S_FIN;
            end
            S_POP: begin
                if (r_idx == '0) begin
                    n_res.wake_valid = 1'b1;
                    n_res.wake_task  = r_rd_data.task_id;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx - AW'(1);
                    wr_data = r_rd_data;
                end
                if ({1'b0, r_idx} == count_m1) begin
                    n_count = count_m1;
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg.valid && i_cfg.ready) begin
            n_ceiling = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_locked     <= 1'b0;
            r_orig       <= '0;
            r_orig_valid <= 1'b0;
            r_ceiling    <= RESET_CEILING;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_locked     <= n_locked;
            r_orig       <= n_orig;
            r_orig_valid <= n_orig_valid;
            r_ceiling    <= n_ceiling;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_idx <= n_idx;
        r_new <= n_new;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out.status;
    assign o_out.boost_valid      = r_out.boost_valid;
    assign o_out.boost_priority   = r_out.boost_priority;
    assign o_out.restore_valid    = r_out.restore_valid;
    assign o_out.restore_priority = r_out.restore_priority;
    assign o_out.wake_valid       = r_out.wake_valid;
    assign o_out.wake_task        = r_out.wake_task;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("wait count above queue depth");

    a_ins_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_pos != '0) && r_locked)
        else $error("insert walk without a hole above the head");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) && (n_state == S_FIN) |=> r_count == $past(count_m1))
        else $error("pop did not remove exactly one waiter");

    a_wake_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.wake_valid |-> o_out.status == ST_RELEASED)
        else $error("wake reported on a lock result");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for priority_ceiling_mutex_core, predicting every result
// transaction from its own model of the ceiling, holder and wait queue.
// depends on pcm_pkg, pcm_in_if, pcm_out_if, pcm_cfg_if and the core itself

module tb;
    import pcm_pkg::*;

    localparam int unsigned WAIT_DEPTH    = 16;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned STALL_LIMIT   = 3000;

    logic clk = 1'b0;
    logic rst_n;

    pcm_in_if  in_if ();
    pcm_cfg_if cfg_if ();
    pcm_out_if out_if ();

    priority_ceiling_mutex_core #(.QUEUE_DEPTH(WAIT_DEPTH)) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mutex model
    logic    mx_locked;
    t_task   mx_holder;
    t_prio   mx_holder_prio;
    logic    mx_holder_prio_ok;
    t_prio   mx_ceiling;
    t_entry  mx_waiters[$];

    t_result     pending_outcomes[$];
    t_entry      woken_tasks[$];
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    logic        sender_gaps_on = 1'b1;
    logic        sink_stalls_on = 1'b1;

    function automatic t_result mutex_outcome(logic op, t_task id, t_prio prio);
        t_result r;
        t_entry  e;
        int      pos;
        r = '0;
        if (op == OP_LOCK) begin
            if (prio < mx_ceiling) mx_ceiling = prio;
            if (!mx_locked) begin
                mx_locked         = 1'b1;
                mx_holder         = id;
                mx_holder_prio    = prio;
                mx_holder_prio_ok = 1'b1;
                r.status          = ST_GRANTED;
                if (mx_ceiling < prio) begin
                    r.boost_valid    = 1'b1;
                    r.boost_priority = mx_ceiling;
                end
            end else if (mx_waiters.size() < WAIT_DEPTH) begin
                // goes behind every waiter of equal or more urgent priority
                e.task_id = id;
                e.prio    = prio;
                pos       = mx_waiters.size();
                while (pos > 0 && mx_waiters[pos-1].prio > prio) pos--;
                mx_waiters.insert(pos, e);
                r.status = ST_QUEUED;
            end else begin
                r.status = ST_FULL;
            end
        end else begin
            if (mx_holder_prio_ok && prio != mx_holder_prio) begin
                r.restore_valid    = 1'b1;
                r.restore_priority = mx_holder_prio;
            end
            mx_holder_prio_ok = 1'b0;
            mx_holder_prio    = '0;
            mx_holder         = '0;
            if (mx_waiters.size() > 0) begin
                e             = mx_waiters.pop_front();
                r.wake_valid  = 1'b1;
                r.wake_task   = e.task_id;
                woken_tasks.push_back(e);
                if (woken_tasks.size() > 32) void'(woken_tasks.pop_front());
            end
            mx_locked = 1'b0;
            r.status  = ST_RELEASED;
        end
        return r;
    endfunction

    function automatic t_prio pick_priority(int unsigned lo);
        if ($urandom_range(0, 99) < 12) return t_prio'($urandom_range(0, 255));
        return t_prio'($urandom_range(lo, 139));
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic issue_request(logic op, t_task id, t_prio prio);
        while (sender_gaps_on && $urandom_range(0, 99) < 24) begin
            in_if.valid         <= 1'b0;
            in_if.operation     <= 1'($urandom_range(0, 1));
            in_if.task_id       <= t_task'($urandom_range(0, 65535));
            in_if.task_priority <= t_prio'($urandom_range(0, 255));
            @(negedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.operation     <= op;
        in_if.task_id       <= id;
        in_if.task_priority <= prio;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        pending_outcomes.push_back(mutex_outcome(op, id, prio));
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_initial_ceiling(t_prio value);
        wait_results_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        mx_ceiling = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= t_prio'($urandom_range(0, 255));
    endtask

    task automatic relock_woken();
        t_entry e;
        e = woken_tasks.pop_front();
        issue_request(OP_LOCK, e.task_id, e.prio);
    endtask

    // unlock of a free mutex with nothing queued
    task automatic test_idle_unlock();
        issue_request(OP_UNLOCK, 16'h0000, 8'd0);
    endtask

    // queue ordering with ties, lock by the holder, drop on full queue
    task automatic test_queue_fill();
        t_prio prios[WAIT_DEPTH] = '{8'd139, 8'd120, 8'd255, 8'd130, 8'd130, 8'd10,
                                     8'd130, 8'd5, 8'd139, 8'd64, 8'd128, 8'd10,
                                     8'd100, 8'd255, 8'd7, 8'd64};
        issue_request(OP_LOCK, 16'h0001, 8'd120);
        for (int i = 0; i < WAIT_DEPTH; i++) begin
            if (i == 1)      issue_request(OP_LOCK, 16'h0001, prios[i]);
            else if (i == 0) issue_request(OP_LOCK, 16'hFFFF, prios[i]);
            else             issue_request(OP_LOCK, t_task'(16'h1000 + i), prios[i]);
        end
        // dropped, but still pulls the ceiling down
        issue_request(OP_LOCK, 16'hBEEF, 8'd3);
    endtask

    task automatic test_release_and_wake();
        issue_request(OP_UNLOCK, 16'h0001, 8'd100);
        issue_request(OP_UNLOCK, 16'h5A5A, 8'd77);
        relock_woken();
        issue_request(OP_UNLOCK, mx_holder, mx_holder_prio);
    endtask

    task automatic test_ceiling_register();
        set_initial_ceiling(8'd139);
        issue_request(OP_LOCK, 16'h2222, 8'd139);
        issue_request(OP_UNLOCK, 16'h2222, 8'd139);
        set_initial_ceiling(8'd0);
        issue_request(OP_LOCK, 16'h8001, 8'd255);
        issue_request(OP_UNLOCK, 16'h8001, 8'd0);
    endtask

    task automatic test_random_traffic();
        t_prio       ceiling_sel;
        int unsigned prio_lo;
        int unsigned lock_pct;
        int unsigned pick;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0:       ceiling_sel = 8'd139;
                1:       ceiling_sel = 8'd0;
                2:       ceiling_sel = 8'd255;
                default: ceiling_sel = t_prio'($urandom_range(0, 139));
            endcase
            set_initial_ceiling(ceiling_sel);
            // one phase runs with no gaps and no stalls at all
            sender_gaps_on = (phase != 4);
            sink_stalls_on = (phase != 4);
            prio_lo  = $urandom_range(0, 120);
            lock_pct = 40 + 15 * $urandom_range(0, 2);
            for (int n = 0; n < 128; n++) begin
                if (woken_tasks.size() > 0 && $urandom_range(0, 99) < 60) begin
                    relock_woken();
                end else if ($urandom_range(0, 99) < lock_pct) begin
                    if (mx_locked && $urandom_range(0, 99) < 10)
                        issue_request(OP_LOCK, mx_holder, pick_priority(prio_lo));
                    else
                        issue_request(OP_LOCK, t_task'($urandom_range(0, 65535)),
                                      pick_priority(prio_lo));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)
                        issue_request(OP_UNLOCK, mx_holder, mx_holder_prio);
                    else if (pick < 75)
                        issue_request(OP_UNLOCK, mx_holder, mx_ceiling);
                    else
                        issue_request(OP_UNLOCK, t_task'($urandom_range(0, 65535)),
                                      pick_priority(0));
                end
            end
        end
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    always @(negedge clk) begin
        out_if.ready <= !sink_stalls_on || ($urandom_range(0, 99) >= 24);
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            error_count++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                error_count++;
                $error("result transaction with nothing outstanding");
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status", 16'(want.status), 16'(out_if.status));
                check_field("boost_valid", 16'(want.boost_valid), 16'(out_if.boost_valid));
                check_field("boost_priority", 16'(want.boost_priority),
                            16'(out_if.boost_priority));
                check_field("restore_valid", 16'(want.restore_valid),
                            16'(out_if.restore_valid));
                check_field("restore_priority", 16'(want.restore_priority),
                            16'(out_if.restore_priority));
                check_field("wake_valid", 16'(want.wake_valid), 16'(out_if.wake_valid));
                check_field("wake_task", want.wake_task, out_if.wake_task);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        rst_n               = 1'b0;
        in_if.valid         = 1'b0;
        in_if.operation     = OP_LOCK;
        in_if.task_id       = '0;
        in_if.task_priority = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.data         = '0;
        out_if.ready        = 1'b0;
        mx_locked           = 1'b0;
        mx_holder           = '0;
        mx_holder_prio      = '0;
        mx_holder_prio_ok   = 1'b0;
        mx_ceiling          = RESET_CEILING;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_unlock();
        test_queue_fill();
        test_release_and_wake();
        test_ceiling_register();
        test_random_traffic();

        wait_results_drained();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
